/* rtl/cluster_eta2_interpolator_assert.svh */
// Assertion macros used by the checker file
`ifndef CLUSTER_ETA2_INTERPOLATOR_ASSERT_SVH
`define CLUSTER_ETA2_INTERPOLATOR_ASSERT_SVH
// Implication checked on every rising edge outside reset
`define CEI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define CEI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/ce2i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ce2i_pkg;
    localparam int QBITS = 2;
    localparam int NMAX = 32;
    localparam int QMAX = 32;
    localparam int DMAX = 34;

    localparam logic MODE_3X3 = 1'b0;
    localparam logic MODE_2X2 = 1'b1;

    // One ratio in flight through the divider row
    typedef struct packed {
        logic [DMAX+QMAX-1:0] rem;
        logic [DMAX-1:0]      den;
        logic [QMAX-1:0]      quo;
        logic                 neg;
        logic                 zero;
    } div_t;
endpackage
`default_nettype wire

/* rtl/cluster_eta2_interpolator.sv */
// Throughput: one cluster per cycle; the whole path is a pipeline that moves
// when the output register is empty or being taken.
// The divider is a row of one-bit restoring cells, one per quotient bit of the
// ratio plus a leading cell whose bit flags a quotient that must saturate.
// Reset (rst_n low, asynchronous) clears the valid bits and sets mode_reg to 3x3.
`timescale 1ns / 1ps
`default_nettype none
module cluster_eta2_interpolator #(
    parameter int PIXEL_BITS = 24,
    parameter int ETA_FRAC_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_data,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // pixel_0 .. pixel_8 from the lowest bit up
    input  wire  [((9*PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // eta_x, eta_y, quad_sum, corner from the lowest bit up
    output logic [((2*ETA_FRAC_BITS+PIXEL_BITS+19)/8)*8-1:0] m_axis_tdata
);
    localparam int EW = ETA_FRAC_BITS + 4;
    localparam int SW = PIXEL_BITS + 2;
    localparam int NB = EW + 1; // ratio bits plus the saturation bit
    localparam int LAT = NB + 2;
    localparam int OW = ((2*EW+SW+2+7)/8)*8;

    logic              mode_reg;
    logic [LAT-1:0]    vld_reg;
    logic              en;
    ce2i_pkg::div_t    cx [NB+1];
    ce2i_pkg::div_t    cy [NB+1];
    logic signed [SW-1:0] s_pipe [NB+1];
    logic [1:0]        c_pipe [NB+1];
    logic [EW-1:0]     ex, ey;
    logic [OW-1:0]     out_reg;

    assign en = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ce2i_pkg::MODE_3X3;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= cfg_data;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    ce2i_front #(.PIXEL_BITS(PIXEL_BITS), .ETA_FRAC_BITS(ETA_FRAC_BITS)) u_front (
        .clk(clk), .en(en), .mode(mode_reg),
        .pix(s_axis_tdata[9*PIXEL_BITS-1:0]),
        .dx(cx[0]), .dy(cy[0]), .sum(s_pipe[0]), .corner(c_pipe[0])
    );

    // divider row, most significant quotient bit first
    for (genvar k = 0; k < NB; k++)
    begin : g_cell
        ce2i_div_cell #(.BIT(NB-1-k)) u_x (.clk(clk), .en(en), .d_in(cx[k]), .d_out(cx[k+1]));
        ce2i_div_cell #(.BIT(NB-1-k)) u_y (.clk(clk), .en(en), .d_in(cy[k]), .d_out(cy[k+1]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_pipe[k+1] <= s_pipe[k];
                c_pipe[k+1] <= c_pipe[k];
            end
        end
    end

    function automatic logic [EW-1:0] sat(input ce2i_pkg::div_t d);
        logic [ce2i_pkg::QMAX-1:0] q;
        logic [ce2i_pkg::QMAX-1:0] lim;
        logic [EW-1:0] r;
        begin
            q = d.quo;
            lim = ce2i_pkg::QMAX'(1) << (EW-1);
            if (d.zero) r = '0;
            else if (d.neg) r = (q > lim) ? EW'(lim) : EW'(-q);
            else r = (q > lim - 1) ? EW'(lim - 1) : EW'(q);
            sat = r;
        end
    endfunction

    assign ex = sat(cx[NB]);
    assign ey = sat(cy[NB]);

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= OW'({c_pipe[NB], s_pipe[NB], ey, ex});
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

/* rtl/ce2i_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step per cell, result bit taken at position BIT
module ce2i_div_cell #(
    parameter int BIT = 0
) (
    input  wire                 clk,
    input  wire                 en,
    input  ce2i_pkg::div_t      d_in,
    output ce2i_pkg::div_t      d_out
);
    localparam int W = ce2i_pkg::DMAX + ce2i_pkg::QMAX;

    ce2i_pkg::div_t cell_reg;
    ce2i_pkg::div_t cell_next;
    logic [W:0]     shifted;
    logic [W:0]     diff;

    // trial subtract of divisor aligned at BIT
    always_comb
    begin
        cell_next = d_in;
        shifted = {1'b0, W'(d_in.den)} << BIT;
        diff = {1'b0, d_in.rem} - shifted;
        if (!diff[W])
        begin
            cell_next.rem = diff[W-1:0];
            cell_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    assign d_out = cell_reg;
endmodule
`default_nettype wire

/* rtl/ce2i_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Quadrant sums, corner pick and ratio operands, one registered stage
module ce2i_front #(
    parameter int PIXEL_BITS = 24,
    parameter int ETA_FRAC_BITS = 16
) (
    input  wire                              clk,
    input  wire                              en,
    input  wire                              mode,
    input  wire signed [9*PIXEL_BITS-1:0]    pix,
    output ce2i_pkg::div_t                   dx,
    output ce2i_pkg::div_t                   dy,
    output logic signed [PIXEL_BITS+1:0]     sum,
    output logic [1:0]                       corner
);
    localparam int SW = PIXEL_BITS + 2;
    localparam int DW = ce2i_pkg::DMAX;

    logic signed [SW-1:0] p [9];
    logic signed [SW-1:0] q [4];
    logic signed [SW-1:0] bsum;
    logic [1:0]           c;
    logic signed [SW-1:0] nx, ny, vx, vy;
    ce2i_pkg::div_t       dx_next, dy_next, dx_reg, dy_reg;
    logic signed [SW-1:0] sum_reg;
    logic [1:0]           corner_reg;

    function automatic ce2i_pkg::div_t mk(input logic signed [SW-1:0] n,
                                          input logic signed [SW-1:0] d);
        ce2i_pkg::div_t r;
        logic [SW-1:0]  mn, md;
        begin
            mn = n[SW-1] ? SW'(-n) : n;
            md = d[SW-1] ? SW'(-d) : d;
            r.rem = (ce2i_pkg::DMAX+ce2i_pkg::QMAX)'(mn) << ETA_FRAC_BITS;
            r.den = DW'(md);
            r.quo = '0;
            r.neg = n[SW-1] ^ d[SW-1];
            r.zero = (d == '0);
            mk = r;
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            p[i] = SW'(signed'(pix[i*PIXEL_BITS +: PIXEL_BITS]));
        q[0] = p[0] + p[1] + p[3] + p[4];
        q[1] = p[1] + p[2] + p[4] + p[5];
        q[2] = p[3] + p[4] + p[6] + p[7];
        q[3] = p[4] + p[5] + p[7] + p[8];
        c = 2'd0;
        bsum = q[0];
        for (int i = 1; i < 4; i++)
            if (q[i] > bsum)
            begin
                bsum = q[i];
                c = 2'(i);
            end
        if (mode == ce2i_pkg::MODE_2X2)
        begin
            c = 2'd0;
            bsum = p[0] + p[1] + p[2] + p[3];
            nx = p[1]; vx = p[0] + p[1];
            ny = p[2]; vy = p[0] + p[2];
        end
        else
        begin
            if (c[0]) begin nx = p[5]; vx = p[4] + p[5]; end
            else      begin nx = p[4]; vx = p[3] + p[4]; end
            if (c[1]) begin ny = p[7]; vy = p[7] + p[4]; end
            else      begin ny = p[4]; vy = p[1] + p[4]; end
        end
        dx_next = mk(nx, vx);
        dy_next = mk(ny, vy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            sum_reg <= bsum;
            corner_reg <= c;
        end
    end

    assign dx = dx_reg;
    assign dy = dy_reg;
    assign sum = sum_reg;
    assign corner = corner_reg;
endmodule
`default_nettype wire

/* rtl/ce2i_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "cluster_eta2_interpolator_assert.svh"
module ce2i_checker (
    input wire clk,
    input wire rst_n,
    input wire s_axis_tready,
    input wire m_axis_tvalid,
    input wire m_axis_tready,
    input wire cfg_ready
);
    // stalled output beat blocks the input side
    `CEI_ASSERT_IMP(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during stall")
    // free output means input open
    `CEI_ASSERT_IMP(a_open, !m_axis_tvalid, s_axis_tready, "input blocked while empty")
    // a stalled beat stays
    `CEI_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped")
    // configuration port always open
    `CEI_ASSERT_IMP(a_cfg, 1'b1, cfg_ready, "cfg not ready")
endmodule

bind cluster_eta2_interpolator ce2i_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .cfg_ready(cfg_ready)
);
`default_nettype wire
